// ===== sv/command_line_number_parser_assert.svh =====
// Assertion helpers, clocked on aclk, off while aresetn is low.
`ifndef COMMAND_LINE_NUMBER_PARSER_ASSERT_SVH
`define COMMAND_LINE_NUMBER_PARSER_ASSERT_SVH

// same-cycle implication
`define CLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/clp_pkg.sv =====
package clp_pkg;

    localparam int MAX_PARAMS_DEF = 4;

    localparam int STATUS_W = 3;
    localparam int LINE_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 3;
    localparam int SLOT_W   = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IGN     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ERR     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ERR_END = 3'd3;
    localparam logic [STATUS_W-1:0] ST_END     = 3'd4;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // largest value that can still take another digit
    localparam logic [VALUE_W-1:0] ACC_LIMIT  = 32'd429496729;
    localparam logic [3:0]         LAST_DIGIT = 4'd5;

    typedef enum logic [2:0] {
        PH_START,
        PH_SECOND,
        PH_REST,
        PH_SKIP,
        PH_COMMENT
    } phase_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [CHAR_W-1:0]   cmd;
        logic [LINE_W-1:0]   line;
    } line_end_t;

endpackage

// ===== sv/clp_parser.sv =====
module clp_parser #(
    parameter int MAX_PARAMS = clp_pkg::MAX_PARAMS_DEF,
    parameter int CW = $clog2(MAX_PARAMS + 1),
    parameter int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_accept,
    input  logic                       action,
    input  logic [clp_pkg::CHAR_W-1:0] byte_value,
    output clp_pkg::line_end_t         line_end,
    output logic [CW-1:0]              line_count,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [clp_pkg::VALUE_W-1:0] wr_data
);

    clp_pkg::phase_t             phase_reg, phase_next;
    logic [clp_pkg::CHAR_W-1:0]  command_reg, command_next;
    logic [clp_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [CW-1:0]               counter_reg, counter_next;
    logic                        inside_reg, inside_next;
    logic [clp_pkg::LINE_W-1:0]  line_reg, line_next;

    logic       ws;
    logic       nl;
    logic       digit;
    logic [3:0] dval;
    logic       fits;
    logic [clp_pkg::VALUE_W-1:0] acc_mul;

    assign ws = (byte_value == clp_pkg::CH_SPACE)
             || ((byte_value >= clp_pkg::CH_TAB) && (byte_value <= clp_pkg::CH_CR));
    assign nl = !action && (byte_value == clp_pkg::CH_NL);
    assign digit = (byte_value >= clp_pkg::CH_ZERO) && (byte_value <= clp_pkg::CH_NINE);
    assign dval = 4'(byte_value - clp_pkg::CH_ZERO);
    assign fits = (acc_reg < clp_pkg::ACC_LIMIT)
               || ((acc_reg == clp_pkg::ACC_LIMIT) && (dval <= clp_pkg::LAST_DIGIT));
    // acc * 10 + d
    assign acc_mul = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                   + {28'd0, dval};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= clp_pkg::PH_START;
            command_reg <= '0;
            acc_reg     <= '0;
            counter_reg <= '0;
            inside_reg  <= 1'b0;
            line_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            acc_reg     <= acc_next;
            counter_reg <= counter_next;
            inside_reg  <= inside_next;
            line_reg    <= line_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        command_next    = command_reg;
        acc_next        = acc_reg;
        counter_next    = counter_reg;
        inside_next     = inside_reg;
        line_next       = line_reg;
        line_end        = '0;
        line_end.line   = line_reg;
        line_count      = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = acc_mul;
        if (in_accept) begin
            case (phase_reg)
                clp_pkg::PH_START: begin
                    line_next     = line_reg + 32'd1;
                    line_end.line = line_next;
                    if (action) begin
                        line_end.valid  = 1'b1;
                        line_end.status = clp_pkg::ST_END;
                    end else if (nl) begin
                        line_end.valid  = 1'b1;
                        line_end.status = clp_pkg::ST_IGN;
                    end else if (byte_value == clp_pkg::CH_HASH) begin
                        phase_next = clp_pkg::PH_COMMENT;
                    end else if (ws) begin
                        phase_next = clp_pkg::PH_SKIP;
                    end else begin
                        command_next = byte_value;
                        phase_next   = clp_pkg::PH_SECOND;
                    end
                end
                clp_pkg::PH_SECOND: begin
                    if (action) begin
                        line_end.valid  = 1'b1;
                        line_end.status = clp_pkg::ST_ERR_END;
                    end else if (nl) begin
                        line_end.valid  = 1'b1;
                        line_end.status = clp_pkg::ST_OK;
                        line_end.cmd    = command_reg;
                    end else if (ws) begin
                        acc_next     = '0;
                        counter_next = '0;
                        inside_next  = 1'b0;
                        phase_next   = clp_pkg::PH_REST;
                    end else begin
                        phase_next = clp_pkg::PH_SKIP;
                    end
                end
                clp_pkg::PH_REST: begin
                    if (action) begin
                        line_end.valid  = 1'b1;
                        line_end.status = clp_pkg::ST_ERR_END;
                    end else if (nl) begin
                        line_end.valid  = 1'b1;
                        line_end.status = clp_pkg::ST_OK;
                        line_end.cmd    = command_reg;
                        line_count      = counter_reg;
                    end else if (ws) begin
                        acc_next    = '0;
                        inside_next = 1'b0;
                    end else if (!inside_reg && (counter_reg >= CW'(MAX_PARAMS))) begin
                        phase_next = clp_pkg::PH_SKIP;
                    end else begin
                        if (!inside_reg) begin
                            counter_next = counter_reg + CW'(1);
                            inside_next  = 1'b1;
                        end
                        if (!digit || !fits) begin
                            phase_next = clp_pkg::PH_SKIP;
                        end else begin
                            acc_next = acc_mul;
                            wr_en    = 1'b1;
                            wr_addr  = AW'(counter_next - CW'(1));
                        end
                    end
                end
                clp_pkg::PH_SKIP: begin
                    if (action) begin
                        line_end.valid  = 1'b1;
                        line_end.status = clp_pkg::ST_ERR_END;
                    end else if (nl) begin
                        line_end.valid  = 1'b1;
                        line_end.status = clp_pkg::ST_ERR;
                    end
                end
                clp_pkg::PH_COMMENT: begin
                    if (action) begin
                        line_end.valid  = 1'b1;
                        line_end.status = clp_pkg::ST_END;
                    end else if (nl) begin
                        line_end.valid  = 1'b1;
                        line_end.status = clp_pkg::ST_IGN;
                    end
                end
                default: begin
                    phase_next = clp_pkg::PH_START;
                end
            endcase
            if (line_end.valid) begin
                phase_next = clp_pkg::PH_START;
            end
        end
    end

endmodule

// ===== sv/clp_emit.sv =====
module clp_emit #(
    parameter int MAX_PARAMS = clp_pkg::MAX_PARAMS_DEF,
    parameter int CW = $clog2(MAX_PARAMS + 1),
    parameter int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  clp_pkg::line_end_t           line_end,
    input  logic [CW-1:0]                line_count,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [clp_pkg::VALUE_W-1:0]  wr_data,
    output logic                         busy,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [79:0]                  m_tdata,
    output logic [3:0]                   m_tuser,
    output logic                         m_tlast
);

    logic [clp_pkg::VALUE_W-1:0] mem [MAX_PARAMS];
    logic [clp_pkg::VALUE_W-1:0] rdata_reg;

    logic                         busy_reg, busy_next;
    logic [clp_pkg::STATUS_W-1:0] status_reg;
    logic [clp_pkg::CHAR_W-1:0]   cmd_reg;
    logic [clp_pkg::LINE_W-1:0]   line_reg;
    logic [CW-1:0]                cnt_reg;
    logic [CW-1:0]                k_reg, k_next;
    logic                         inflight_reg, inflight_next;
    logic [CW-1:0]                slot_reg;

    logic                         m_valid_reg, m_valid_next;
    logic [clp_pkg::STATUS_W-1:0] m_status_reg;
    logic [clp_pkg::CHAR_W-1:0]   m_cmd_reg;
    logic [clp_pkg::COUNT_W-1:0]  m_count_reg;
    logic [clp_pkg::LINE_W-1:0]   m_line_reg;
    logic [clp_pkg::SLOT_W-1:0]   m_slot_reg;
    logic [clp_pkg::VALUE_W-1:0]  m_value_reg;
    logic                         m_present_reg;
    logic                         m_last_reg;

    logic out_free;
    logic has_nums;
    logic issue;
    logic load_num;
    logic load_none;
    logic slot_last;

    assign out_free  = !m_valid_reg || m_tready;
    assign has_nums  = (cnt_reg != '0);
    assign issue     = busy_reg && has_nums && (k_reg != cnt_reg)
                    && (!inflight_reg || out_free);
    assign load_num  = inflight_reg && out_free;
    assign load_none = busy_reg && !has_nums && out_free;
    assign slot_last = ((slot_reg + CW'(1)) == cnt_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rdata_reg <= mem[k_reg[AW-1:0]];
        end
    end

    always_comb begin
        busy_next     = busy_reg;
        k_next        = k_reg;
        inflight_next = inflight_reg;
        m_valid_next  = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_num || load_none) begin
            m_valid_next = 1'b1;
        end
        if (load_none || (load_num && slot_last)) begin
            busy_next = 1'b0;
        end
        if (load_num) begin
            inflight_next = 1'b0;
        end
        if (issue) begin
            inflight_next = 1'b1;
            k_next        = k_reg + CW'(1);
        end
        if (line_end.valid) begin
            busy_next = 1'b1;
            k_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            k_reg        <= '0;
            inflight_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            k_reg        <= k_next;
            inflight_reg <= inflight_next;
            m_valid_reg  <= m_valid_next;
        end
        if (line_end.valid) begin
            status_reg <= line_end.status;
            cmd_reg    <= line_end.cmd;
            line_reg   <= line_end.line;
            cnt_reg    <= line_count;
        end
        if (issue) begin
            slot_reg <= k_reg;
        end
        if (load_num) begin
            m_status_reg  <= status_reg;
            m_cmd_reg     <= cmd_reg;
            m_count_reg   <= clp_pkg::COUNT_W'(cnt_reg);
            m_line_reg    <= line_reg;
            m_slot_reg    <= clp_pkg::SLOT_W'(slot_reg);
            m_value_reg   <= rdata_reg;
            m_present_reg <= 1'b1;
            m_last_reg    <= slot_last;
        end else if (load_none) begin
            m_status_reg  <= status_reg;
            m_cmd_reg     <= cmd_reg;
            m_count_reg   <= '0;
            m_line_reg    <= line_reg;
            m_slot_reg    <= '0;
            m_value_reg   <= '0;
            m_present_reg <= 1'b0;
            m_last_reg    <= 1'b1;
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_value_reg, m_slot_reg, m_line_reg, m_count_reg, m_cmd_reg};
    assign m_tuser  = {m_present_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== sv/command_line_number_parser.sv =====
// channel  | dir | tdata                            | tuser                     | tlast
// ---------+-----+----------------------------------+---------------------------+-------------
// s_       | in  | byte_value[7:0]                  | action                    | -
// m_       | out | command_char, param_count,       | line_status[2:0],         | last_of_line
//          |     | line_index, param_slot,          | param_present[3]          |
//          |     | param_value (bits 0..76)         |                           |
//
// One input word per cycle while no line end is pending.
// A line end holds s_tready low until all its result words are loaded; stored numbers are
// read through the registered store read port, then loaded one number per cycle while m_tready is high.
// m_tready low stretches that stall; plain bytes are still taken.
// aresetn is synchronous; the number store has no reset.
module command_line_number_parser #(
    parameter int MAX_PARAMS = clp_pkg::MAX_PARAMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value[7:0]
    input  logic [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // command_char[7:0], param_count[10:8], line_index[42:11],
                                   // param_slot[44:43], param_value[76:45], zero[79:77]
    output logic [3:0]  m_tuser,   // line_status[2:0], param_present[3]
    output logic        m_tlast    // last_of_line
);

    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    clp_pkg::line_end_t          line_end;
    logic [CW-1:0]               line_count;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [clp_pkg::VALUE_W-1:0] wr_data;
    logic                        busy;
    logic                        in_accept;

    assign s_tready  = !busy;
    assign in_accept = s_tvalid && s_tready;

    clp_parser #(
        .MAX_PARAMS (MAX_PARAMS),
        .CW         (CW),
        .AW         (AW)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .action     (s_tuser[0]),
        .byte_value (s_tdata),
        .line_end   (line_end),
        .line_count (line_count),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    clp_emit #(
        .MAX_PARAMS (MAX_PARAMS),
        .CW         (CW),
        .AW         (AW)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_end   (line_end),
        .line_count (line_count),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .busy       (busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== sv/clp_check.sv =====
`include "command_line_number_parser_assert.svh"

module clp_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    `CLP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "result word changed while stalled")
    `CLP_ASSERT_NOW(a_none_is_last, m_tvalid && !m_tuser[3],
        m_tlast && (m_tdata[76:43] == '0), "numberless result not alone")
    `CLP_ASSERT_NOW(a_present_ok, m_tvalid && m_tuser[3],
        m_tuser[2:0] == clp_pkg::ST_OK, "number on a non-ok line")
    `CLP_ASSERT_NOW(a_bad_clear, m_tvalid && (m_tuser[2:0] != clp_pkg::ST_OK),
        m_tdata[10:0] == '0, "command or count on a non-ok line")

endmodule

bind command_line_number_parser clp_check u_clp_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/command_line_number_parser_tb.sv =====
module command_line_number_parser_tb;
    import clp_pkg::*;

    localparam int       CYCLE_LIMIT = 200000;
    localparam int       SETTLE_CYCLES = 20;
    localparam int       MAX_REPORTS = 10;
    localparam logic     ACT_DATA = 1'b0;
    localparam logic     ACT_END = 1'b1;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [CHAR_W-1:0]   cmd;
        logic [COUNT_W-1:0]  count;
        logic [LINE_W-1:0]   line;
        logic [SLOT_W-1:0]   slot;
        logic [VALUE_W-1:0]  value;
        logic                present;
        logic                last;
    } line_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int sender_idle_pct = 11;
    int receiver_stall_pct = 61;
    int cycle_count = 0;
    int mismatches = 0;
    int words_sent = 0;
    int results_checked = 0;
    int lines_parsed = 0;

    // parser model state
    phase_t             parse_phase = PH_START;
    logic [CHAR_W-1:0]  command_reg = '0;
    logic [VALUE_W-1:0] accumulator = '0;
    logic [COUNT_W-1:0] number_count = '0;
    logic               in_number = 1'b0;
    logic [VALUE_W-1:0] number_store [MAX_PARAMS_DEF];
    logic [LINE_W-1:0]  line_counter = '0;

    line_result_t line_results_due[$];

    command_line_number_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // byte_value[7:0]
        .s_tuser  (s_tuser),   // action[0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // command_char, param_count, line_index, param_slot, param_value
        .m_tuser  (m_tuser),   // line_status[2:0], param_present[3]
        .m_tlast  (m_tlast)    // last_of_line
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, line_results_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic emit_line(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
        line_result_t r;
        int n;
        n = (status == ST_OK) ? int'(count) : 0;
        parse_phase = PH_START;
        r.status = status;
        r.cmd = (status == ST_OK) ? command_reg : '0;
        r.count = COUNT_W'(n);
        r.line = line_counter;
        r.slot = '0;
        r.value = '0;
        r.present = 1'b0;
        r.last = 1'b1;
        if (n == 0) begin
            line_results_due.push_back(r);
        end else begin
            for (int k = 0; k < n; k++) begin
                r.slot = SLOT_W'(k);
                r.value = number_store[k];
                r.present = 1'b1;
                r.last = (k + 1 == n);
                line_results_due.push_back(r);
            end
        end
    endtask

    task automatic parse_word(logic act, logic [7:0] c);
        bit at_end;
        bit nl;
        bit rejected;
        logic [3:0] digit;
        at_end = (act == ACT_END);
        nl = !at_end && c == CH_NL;
        case (parse_phase)
            PH_START: begin
                line_counter = line_counter + 1;
                lines_parsed++;
                if (at_end) emit_line(ST_END, '0);
                else if (nl) emit_line(ST_IGN, '0);
                else if (c == CH_HASH) parse_phase = PH_COMMENT;
                else if (is_space(c)) parse_phase = PH_SKIP;
                else begin
                    command_reg = c;
                    parse_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (at_end) emit_line(ST_ERR_END, '0);
                else if (nl) emit_line(ST_OK, '0);
                else if (is_space(c)) begin
                    accumulator = '0;
                    number_count = '0;
                    in_number = 1'b0;
                    parse_phase = PH_REST;
                end else begin
                    parse_phase = PH_SKIP;
                end
            end
            PH_REST: begin
                if (at_end) emit_line(ST_ERR_END, '0);
                else if (nl) emit_line(ST_OK, number_count);
                else if (is_space(c)) begin
                    accumulator = '0;
                    in_number = 1'b0;
                end else begin
                    rejected = 1'b0;
                    if (!in_number) begin
                        if (number_count >= MAX_PARAMS_DEF) begin
                            parse_phase = PH_SKIP;
                            rejected = 1'b1;
                        end else begin
                            number_count = number_count + 1;
                            in_number = 1'b1;
                        end
                    end
                    if (!rejected) begin
                        if (c < CH_ZERO || c > CH_NINE) begin
                            parse_phase = PH_SKIP;
                        end else begin
                            digit = 4'(c - CH_ZERO);
                            if (accumulator < ACC_LIMIT ||
                                (accumulator == ACC_LIMIT && digit <= LAST_DIGIT)) begin
                                accumulator = accumulator * 10 + digit;
                                number_store[(int'(number_count) - 1) % MAX_PARAMS_DEF] =
                                    accumulator;
                            end else begin
                                parse_phase = PH_SKIP;
                            end
                        end
                    end
                end
            end
            PH_SKIP: begin
                if (at_end) emit_line(ST_ERR_END, '0);
                else if (nl) emit_line(ST_ERR, '0);
            end
            PH_COMMENT: begin
                if (at_end) emit_line(ST_END, '0);
                else if (nl) emit_line(ST_IGN, '0);
            end
            default: parse_phase = PH_START;
        endcase
    endtask

    task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on result %0d: %s expected %0h got %0h",
                         results_checked, name, exp_val, act_val);
        end
    endtask

    task automatic check_result();
        line_result_t r;
        if (line_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result word: tdata %0h tuser %0h tlast %0b",
                         m_tdata, m_tuser, m_tlast);
        end else begin
            r = line_results_due.pop_front();
            compare_field("line_status", 32'(r.status), 32'(m_tuser[2:0]));
            compare_field("command_char", 32'(r.cmd), 32'(m_tdata[7:0]));
            compare_field("param_count", 32'(r.count), 32'(m_tdata[10:8]));
            compare_field("line_index", r.line, m_tdata[42:11]);
            compare_field("param_slot", 32'(r.slot), 32'(m_tdata[44:43]));
            compare_field("param_value", r.value, m_tdata[76:45]);
            compare_field("param_present", 32'(r.present), 32'(m_tuser[3]));
            compare_field("last_of_line", 32'(r.last), 32'(m_tlast));
        end
        results_checked++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) parse_word(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) check_result();
        end
    end

    task automatic send_word(logic act, logic [7:0] c);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = c;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(ACT_DATA, s[i]);
    endtask

    task automatic send_nl();
        send_word(ACT_DATA, CH_NL);
    endtask

    task automatic send_end();
        send_word(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_number(longint unsigned v);
        send_text($sformatf("%0d", v));
    endtask

    function automatic logic [7:0] random_space();
        case ($urandom_range(0, 4))
            0: return CH_TAB;
            1: return CH_VT;
            2: return CH_FF;
            3: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic send_gap();
        repeat ($urandom_range(1, 2)) send_word(ACT_DATA, random_space());
    endtask

    function automatic logic [7:0] random_command();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_space(c) || c == CH_HASH);
        return c;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 32'($urandom_range(0, 999));
            2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 9));
            3: return ACC_LIMIT * 10 - 32'($urandom_range(0, 20));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_numbers(int n);
        for (int k = 0; k < n; k++) begin
            if (k > 0) send_gap();
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_word(ACT_DATA, CH_ZERO);
            send_number(random_value());
        end
    endtask

    task automatic finish_line();
        if ($urandom_range(0, 9) == 0) send_end();
        else send_nl();
    endtask

    task automatic send_random_line();
        int kind;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            send_word(ACT_DATA, random_command());
            send_gap();
            send_numbers($urandom_range(0, MAX_PARAMS_DEF));
            if ($urandom_range(0, 3) == 0) send_gap();
            finish_line();
        end else if (kind < 80) begin
            send_word(ACT_DATA, random_command());
            case ($urandom_range(0, 3))
                0: begin
                    send_gap();
                    send_number(64'd4294967296 + longint'($urandom_range(0, 1 << 20)));
                end
                1: begin
                    send_gap();
                    send_numbers($urandom_range(MAX_PARAMS_DEF + 1, MAX_PARAMS_DEF + 2));
                end
                2: begin
                    send_gap();
                    send_numbers($urandom_range(0, 2));
                    do c = 8'($urandom_range(0, 255));
                    while (is_space(c) || (c >= CH_ZERO && c <= CH_NINE));
                    send_word(ACT_DATA, c);
                    send_text("12");
                end
                default: begin
                    send_word(ACT_DATA, random_command());
                    send_text(" 5");
                end
            endcase
            finish_line();
        end else if (kind < 87) begin
            send_word(ACT_DATA, CH_HASH);
            repeat ($urandom_range(0, 6)) send_word(ACT_DATA, 8'($urandom_range(0, 255)));
            finish_line();
        end else if (kind < 94) begin
            case ($urandom_range(0, 2))
                0: send_nl();
                1: send_end();
                default: begin
                    send_word(ACT_DATA, random_space());
                    send_text("A 1");
                    send_nl();
                end
            endcase
        end else begin
            repeat ($urandom_range(3, 10))
                send_word($urandom_range(0, 9) == 0 ? ACT_END : ACT_DATA,
                          8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (line_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic test_line_ends();
        send_end();
        send_nl();
        send_text("A");
        send_nl();
        send_text("B");
        send_end();
    endtask

    task automatic test_comments();
        send_text("#x");
        send_nl();
        send_text("#");
        send_end();
    endtask

    task automatic test_bad_spacing();
        send_word(ACT_DATA, CH_TAB);
        send_text("1");
        send_nl();
        send_text("Cx");
        send_nl();
    endtask

    task automatic test_numbers();
        send_word(ACT_DATA, 8'hFF);
        send_text(" 4294967295");
        send_word(ACT_DATA, CH_TAB);
        send_text("007");
        send_nl();
        send_text("D 0 1 2 3");
        send_nl();
    endtask

    task automatic test_parse_errors();
        send_text("E 4294967296");
        send_nl();
        send_text("F 1 2 3 4 5");
        send_nl();
        send_text("G 12a");
        send_nl();
        send_text("H 7 8");
        send_end();
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int word_budget);
        int stop_at;
        wait_drained();
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        stop_at = words_sent + word_budget;
        while (words_sent < stop_at) send_random_line();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_line_ends();
        test_comments();
        test_bad_spacing();
        test_numbers();
        test_parse_errors();
        test_random_traffic(11, 61, 40);
        test_random_traffic(61, 11, 40);
        test_random_traffic(0, 0, 40);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (line_results_due.size() != 0) mismatches++;

        $display("Parsed %0d lines from %0d input words; %0d result words compared.",
                 lines_parsed, words_sent, results_checked);
        $display("Covered comments, empty lines, end marks, overflow and excess numbers,");
        $display("%0d mismatches.", mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/clp_pkg.sv
sv/clp_parser.sv
sv/clp_emit.sv
sv/command_line_number_parser.sv
sv/clp_check.sv
tb/command_line_number_parser_tb.sv
